// ----- rtl/core/dgu_pkg.sv -----
// Package for the density gamma 3x upscaler: shared types, constants, filter helpers.
// Used by dgu_front, dgu_back and the top level under rtl/core; depends on nothing.
`default_nettype none
package dgu_pkg;
   localparam int unsigned VAL_W = 17;
   localparam int unsigned POS_W = 9;
   localparam int unsigned MAX_GRID = 256;
   localparam logic [VAL_W-1:0] ONE_Q16 = 17'd65536;

   typedef enum logic [1:0] {
      GAMMA_POW34 = 2'd0,
      GAMMA_SQRT  = 2'd1,
      GAMMA_IDENT = 2'd2,
      GAMMA_RSVD  = 2'd3
   } gamma_type;

   localparam logic [1:0] CSR_GRID   = 2'd0;
   localparam logic [1:0] CSR_GAMMA  = 2'd1;
   localparam logic [1:0] CSR_FILTER = 2'd2;

   // One classified sample handed from the front to the back.
   typedef struct packed {
      logic [VAL_W-1:0] m00, m01, m02; // row r-2: cols c-2, c-1, c
      logic [VAL_W-1:0] m10, m11, m12; // row r-1
      logic [VAL_W-1:0] m20, m21, m22; // row r
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             filt;          // emit nine subpixels
   } job_type;

   // floor(x/9) for x < 9*65536*2: multiply by reciprocal, then one correction
   function automatic logic [VAL_W-1:0] div9(input logic [20:0] x);
      logic [41:0] p;
      logic [20:0] q;
      logic [20:0] rem;
      p   = 42'(x) * 42'd233017;      // ceil(2^21/9)
      q   = p[41:21];
      rem = x - 21'(q * 21'd9);
      if (rem >= 21'd9) q = q + 21'd1;
      return q[VAL_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/core/dgu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dgu_ram #(
   parameter int unsigned WIDTH = 17,
   parameter int unsigned DEPTH = 258
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/dgu_isqrt.sv -----
// Iterative integer square root, one result bit per cycle (64-bit radicand).
// No package dependency.
`default_nettype none
module dgu_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             busy,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] x_ff, x_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [65:0] trial;
   logic [65:0] acc;

   always_comb begin
      rem_in = rem_ff; root_in = root_ff; x_in = x_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      acc   = {rem_ff, x_ff[63:62]};
      trial = {32'd0, root_ff, 2'b01};
      if (start) begin
         rem_in = '0; root_in = '0; x_in = radicand; cnt_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[61:0], 2'b00};
         if (acc >= trial) begin
            rem_in  = 64'(acc - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = acc[63:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; root_ff <= root_in; x_ff <= x_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// ----- rtl/core/dgu_front.sv -----
// Front end: accepts samples, gamma-maps them, tracks position, maintains
// line store and window, and pushes jobs. Depends on dgu_pkg, dgu_ram, dgu_isqrt.
`default_nettype none
module dgu_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [23:0]               density,
   input  wire logic                      frame_start,
   input  wire logic [8:0]                grid_size,
   input  wire logic [1:0]                gamma_mode,
   input  wire logic                      filter_enable,
   output logic                           job_valid,
   output dgu_pkg::job_type               job,
   input  wire logic                      job_ready
);
   localparam int unsigned LINE_W = dgu_pkg::MAX_GRID + 2;
   localparam int unsigned AW = $clog2(LINE_W);
   localparam int unsigned PW = dgu_pkg::POS_W;
   localparam int unsigned VW = dgu_pkg::VAL_W;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SQ1, S_SQ2, S_READ, S_PUSH} state_type;
   state_type state_ff;

   logic [23:0] dens_ff;
   logic        fs_ff;
   logic [31:0] sqr_ff;
   logic [PW-1:0] col_ff, row_ff, c_ff, r_ff;
   logic [AW-1:0] clr_ff;
   logic [VW-1:0] x_ff;
   logic [VW-1:0] w_ff [3][2];
   logic          filt_ff;
   logic [VW-1:0] clamp_in;
   logic [VW-1:0] clamp;
   logic [47:0]   cube;
   logic [PW:0]   w_cur;
   logic [PW-1:0] g_sat;
   logic [PW-1:0] c_pos;
   logic          need_root;
   logic          sq_start, sq_busy, sq_done;
   logic [63:0]   sq_in;
   logic [31:0]   sq_root;
   logic [VW-1:0] l0_rd, l1_rd;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_d0, wr_d1;

   assign clamp_in = (density > 24'(dgu_pkg::ONE_Q16)) ? dgu_pkg::ONE_Q16 : density[VW-1:0];
   assign clamp = (dens_ff > 24'(dgu_pkg::ONE_Q16)) ? dgu_pkg::ONE_Q16 : dens_ff[VW-1:0];
   // square is registered at accept; the cube only matters below full scale
   assign cube  = 48'(sqr_ff) * 48'(clamp[15:0]);
   assign g_sat = (grid_size == '0) ? PW'(1) :
                  (grid_size > PW'(dgu_pkg::MAX_GRID)) ? PW'(dgu_pkg::MAX_GRID) : grid_size;
   assign w_cur = (PW+1)'(g_sat) + (PW+1)'(2);
   assign c_pos = (fs_ff ? '0 : ((32'(col_ff) >= LINE_W) ? '0 : col_ff));
   assign need_root = (gamma_mode == dgu_pkg::GAMMA_SQRT) ||
                      (gamma_mode == dgu_pkg::GAMMA_POW34 && clamp != dgu_pkg::ONE_Q16);

   dgu_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_in),
      .busy(sq_busy), .done(sq_done), .root(sq_root)
   );

   dgu_ram #(.WIDTH(VW), .DEPTH(LINE_W)) u_line0 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_d0),
      .rd_addr(c_pos[AW-1:0]), .rd_data(l0_rd)
   );
   dgu_ram #(.WIDTH(VW), .DEPTH(LINE_W)) u_line1 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_d1),
      .rd_addr(c_pos[AW-1:0]), .rd_data(l1_rd)
   );

   // clearing pass after reset writes zero to every line-store entry
   assign req_tready = (state_ff == S_IDLE);
   assign job_valid  = (state_ff == S_PUSH);
   assign wr_en      = ((state_ff == S_PUSH) && job_ready) || (state_ff == S_CLEAR);
   assign wr_addr    = (state_ff == S_CLEAR) ? clr_ff : c_ff[AW-1:0];
   assign wr_d0      = (state_ff == S_CLEAR) ? '0 : l1_rd;
   assign wr_d1      = (state_ff == S_CLEAR) ? '0 : x_ff;

   always_comb begin
      sq_start = 1'b0;
      sq_in    = {32'd0, sq_root};
      if (state_ff == S_SQ1 && need_root && !sq_busy && !sq_done) begin
         sq_start = 1'b1;
         sq_in = (gamma_mode == dgu_pkg::GAMMA_POW34) ? {cube, 16'd0}
                                                     : {31'd0, clamp, 16'd0};
      end
      if (state_ff == S_SQ2 && !sq_busy && !sq_done) begin
         sq_start = 1'b1;
         sq_in = {32'd0, sq_root};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         col_ff <= '0; row_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            w_ff[k][0] <= '0; w_ff[k][1] <= '0;
         end
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(LINE_W - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_tvalid) begin
               dens_ff <= density; fs_ff <= frame_start; state_ff <= S_SQ1;
               sqr_ff  <= 32'(clamp_in[15:0]) * 32'(clamp_in[15:0]);
            end
            S_SQ1: begin
               filt_ff <= filter_enable;
               c_ff    <= c_pos;
               r_ff    <= fs_ff ? '0 : row_ff;
               if (!need_root) begin
                  x_ff <= clamp; state_ff <= S_READ;
               end else if (sq_done) begin
                  if (gamma_mode == dgu_pkg::GAMMA_SQRT) begin
                     x_ff <= sq_root[VW-1:0]; state_ff <= S_READ;
                  end else state_ff <= S_SQ2;
               end
            end
            S_SQ2: if (sq_done) begin
               x_ff <= sq_root[VW-1:0]; state_ff <= S_READ;
            end
            S_READ: state_ff <= S_PUSH;
            S_PUSH: if (job_ready) begin
               state_ff <= S_IDLE;
               w_ff[0][0] <= w_ff[0][1]; w_ff[0][1] <= job.m02;
               w_ff[1][0] <= w_ff[1][1]; w_ff[1][1] <= job.m12;
               w_ff[2][0] <= w_ff[2][1]; w_ff[2][1] <= x_ff;
               if ((PW+1)'(c_ff) + (PW+1)'(1) >= w_cur) begin
                  col_ff <= '0;
                  row_ff <= ((PW+1)'(r_ff) + (PW+1)'(1) >= w_cur) ? '0 : r_ff + PW'(1);
               end else begin
                  col_ff <= c_ff + PW'(1);
                  row_ff <= ((PW+1)'(r_ff) >= w_cur) ? '0 : r_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      job.m00 = w_ff[0][0]; job.m01 = w_ff[0][1]; job.m02 = l0_rd;
      job.m10 = w_ff[1][0]; job.m11 = w_ff[1][1]; job.m12 = l1_rd;
      job.m20 = w_ff[2][0]; job.m21 = w_ff[2][1]; job.m22 = x_ff;
      job.col = c_ff; job.row = r_ff; job.filt = filt_ff;
   end
endmodule
`default_nettype wire

// ----- rtl/core/dgu_back.sv -----
// Back end: pops jobs from a two-entry queue and emits subpixels or the plain value;
// filtered jobs with col or row below 2 are dropped. Depends on dgu_pkg.
`default_nettype none
module dgu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire dgu_pkg::job_type  job,
   output logic                   job_ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [39:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   localparam int unsigned VW = dgu_pkg::VAL_W;
   localparam int unsigned PW = dgu_pkg::POS_W;

   dgu_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic [1:0] sx_ff, sy_ff;
   logic       out_v_ff;
   logic [VW-1:0] val_ff;
   logic [PW-1:0] oc_ff, or_ff;
   logic [1:0]    osx_ff, osy_ff;
   logic          olast_ff;
   logic          push, pop, adv, skip;
   dgu_pkg::job_type h;
   logic [VW-1:0] d, hh, u, cc, v;
   logic [20:0]   sum;
   logic          fin;

   assign job_ready = (cnt_ff != 2'd2);
   assign push = job_valid && job_ready;
   assign h    = q_ff[rp_ff];
   assign skip = h.filt && (h.col < PW'(2) || h.row < PW'(2));
   assign adv  = (cnt_ff != 2'd0) && !skip && (!out_v_ff || rsp_tready);
   assign fin  = !h.filt || (sx_ff == 2'd2 && sy_ff == 2'd2);
   assign pop  = (cnt_ff != 2'd0) && (skip || (adv && fin));

   always_comb begin
      cc = h.m11;
      case (sx_ff)
         2'd0: hh = h.m10;
         2'd2: hh = h.m12;
         default: hh = h.m11;
      endcase
      case (sy_ff)
         2'd0: u = h.m01;
         2'd2: u = h.m21;
         default: u = h.m11;
      endcase
      case ({sy_ff, sx_ff})
         4'b0000: d = h.m00;
         4'b0010: d = h.m02;
         4'b1000: d = h.m20;
         4'b1010: d = h.m22;
         default: d = h.m11;
      endcase
      if (sx_ff == 2'd1 && sy_ff == 2'd1) sum = 21'(cc) * 21'd9;
      else if (sx_ff == 2'd1) sum = 21'(u) * 21'd3 + 21'(cc) * 21'd6;
      else if (sy_ff == 2'd1) sum = 21'(hh) * 21'd3 + 21'(cc) * 21'd6;
      else sum = 21'(d) + 21'(hh) * 21'd2 + 21'(u) * 21'd2 + 21'(cc) * 21'd4;
      v = h.filt ? dgu_pkg::div9(sum) : h.m22;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
         sx_ff <= '0; sy_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         if (push) begin q_ff[wp_ff] <= job; wp_ff <= ~wp_ff; end
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (adv) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         if (adv) begin
            val_ff <= v;
            oc_ff  <= h.filt ? h.col - PW'(1) : h.col;
            or_ff  <= h.filt ? h.row - PW'(1) : h.row;
            osx_ff <= h.filt ? sx_ff : 2'd0;
            osy_ff <= h.filt ? sy_ff : 2'd0;
            olast_ff <= fin;
            if (fin) begin sx_ff <= '0; sy_ff <= '0; end
            else if (sx_ff == 2'd2) begin sx_ff <= '0; sy_ff <= sy_ff + 2'd1; end
            else sx_ff <= sx_ff + 2'd1;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {1'b0, osy_ff, osx_ff, or_ff, oc_ff, val_ff};
endmodule
`default_nettype wire

// ----- rtl/core/density_gamma_3x_upscaler_top.sv -----
// Density gamma 3x upscaler top level.
// Identity mode (and power mode at full scale) needs no square root; square-root mode uses one,
// power mode two serial roots, all on the shared square-root unit, which limits the sample rate.
// The front takes a new sample while the back still emits the last one's words; nine-subpixel
// output is one word per cycle while rsp_tready is high.
// Reset (sync, active high) restores registers, position and window, then clears the line
// store with req_tready low.
`default_nettype none
module density_gamma_3x_upscaler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // density[23:0]
   input  wire logic        req_tuser,   // frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // value[16:0], cell_col, cell_row, sub_col, sub_row
   output logic             rsp_tlast,   // last
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   logic [8:0] grid_ff;
   logic [1:0] gamma_ff;
   logic       filt_ff;
   logic       job_valid, job_ready;
   dgu_pkg::job_type job;

   // hold configuration; write only while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= 9'd101; gamma_ff <= dgu_pkg::GAMMA_POW34; filt_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            dgu_pkg::CSR_GRID:   grid_ff  <= csr_wdata;
            dgu_pkg::CSR_GAMMA:  gamma_ff <= csr_wdata[1:0];
            dgu_pkg::CSR_FILTER: filt_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   dgu_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .density(req_tdata), .frame_start(req_tuser), .grid_size(grid_ff),
      .gamma_mode(gamma_ff), .filter_enable(filt_ff), .job_valid(job_valid),
      .job(job), .job_ready(job_ready)
   );

   dgu_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_ready(job_ready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for the density gamma 3x upscaler: streams density frames under
// several register settings, predicts every output word and compares field by field.
// Depends on dgu_pkg and density_gamma_3x_upscaler_top.
module testbench;

   typedef struct {
      logic [23:0] density;
      logic        frame_start;
   } sample_type;

   typedef struct {
      logic [16:0] value;
      logic [8:0]  cell_col;
      logic [8:0]  cell_row;
      logic [1:0]  sub_col;
      logic [1:0]  sub_row;
      logic        last;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = dgu_pkg::CSR_GRID;
   logic [8:0]  csr_wdata = '0;

   density_gamma_3x_upscaler_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [8:0]         grid_reg;
   dgu_pkg::gamma_type gamma_reg;
   logic               filter_reg;
   logic [16:0] row_hist[2][258];
   logic [16:0] win_hist[3][2];
   int unsigned col_pos, row_pos;

   sample_type  pending_samples[$];
   pixel_type   expected_pixels[$];
   int          error_count = 0;
   int          gap_left = 0, stall_left = 0;
   bit          quiet_tail = 0;
   int          idle_cycles = 0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd4294967295;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= x) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic logic [16:0] gamma_curve(input logic [23:0] raw);
      longint unsigned v;
      v = (raw > 24'd65536) ? 65536 : raw;
      case (gamma_reg)
         dgu_pkg::GAMMA_POW34: begin
            if (v >= 65536) return 17'd65536;
            return 17'(floor_sqrt(floor_sqrt((v * v * v) << 16)));
         end
         dgu_pkg::GAMMA_SQRT: return 17'(floor_sqrt(v << 16));
         default: return 17'(v);
      endcase
   endfunction

   // compute the words caused by one sample and advance the frame position
   task automatic upscale_sample(input sample_type s);
      int unsigned g, w, c, r, cc, h, u, d, val;
      logic [16:0] x;
      logic [16:0] col3[3];
      logic [16:0] m[3][3];
      pixel_type p;
      g = grid_reg;
      if (g < 1) g = 1;
      if (g > 256) g = 256;
      w = g + 2;
      if (s.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      if (c >= 258) c = 0;
      x = gamma_curve(s.density);
      col3[0] = row_hist[0][c];
      col3[1] = row_hist[1][c];
      col3[2] = x;
      if (filter_reg) begin
         if (c >= 2 && r >= 2) begin
            for (int k = 0; k < 3; k++) begin
               m[k][0] = win_hist[k][0];
               m[k][1] = win_hist[k][1];
               m[k][2] = col3[k];
            end
            for (int sy = 0; sy < 3; sy++)
               for (int sx = 0; sx < 3; sx++) begin
                  cc = m[1][1]; h = m[1][sx]; u = m[sy][1]; d = m[sy][sx];
                  if (sx == 1 && sy == 1) val = cc;
                  else if (sx == 1) val = (3 * u + 6 * cc) / 9;
                  else if (sy == 1) val = (3 * h + 6 * cc) / 9;
                  else val = (d + 2 * h + 2 * u + 4 * cc) / 9;
                  p.value = 17'(val);
                  p.cell_col = 9'(c - 1);
                  p.cell_row = 9'(r - 1);
                  p.sub_col = 2'(sx);
                  p.sub_row = 2'(sy);
                  p.last = (sx == 2 && sy == 2);
                  expected_pixels.push_back(p);
               end
         end
      end else begin
         p.value = x;
         p.cell_col = 9'(c);
         p.cell_row = 9'(r);
         p.sub_col = 2'd0;
         p.sub_row = 2'd0;
         p.last = 1'b1;
         expected_pixels.push_back(p);
      end
      for (int k = 0; k < 3; k++) begin
         win_hist[k][0] = win_hist[k][1];
         win_hist[k][1] = col3[k];
      end
      row_hist[0][c] = col3[1];
      row_hist[1][c] = x;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= w) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = (r >= w) ? 0 : r;
      end
   endtask

   // driver: offer the head of the queue, predict on acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            upscale_sample(pending_samples.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if ((!req_tvalid || req_tready) && !quiet_tail
                      && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 17) - 1;
            req_tvalid <= 1'b0;
         end else if (req_tvalid && !req_tready) begin
            // hold the word until it is taken
         end else if (pending_samples.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_samples[0].density;
            req_tuser <= pending_samples[0].frame_start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: check each accepted word against the oldest expectation
   always @(posedge clock) begin
      pixel_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_tdata[16:0] != e.value)
                  report($sformatf("value %0d exp %0d", rsp_tdata[16:0], e.value));
               if (rsp_tdata[25:17] != e.cell_col)
                  report($sformatf("cell_col %0d exp %0d", rsp_tdata[25:17], e.cell_col));
               if (rsp_tdata[34:26] != e.cell_row)
                  report($sformatf("cell_row %0d exp %0d", rsp_tdata[34:26], e.cell_row));
               if (rsp_tdata[36:35] != e.sub_col)
                  report($sformatf("sub_col %0d exp %0d", rsp_tdata[36:35], e.sub_col));
               if (rsp_tdata[38:37] != e.sub_row)
                  report($sformatf("sub_row %0d exp %0d", rsp_tdata[38:37], e.sub_row));
               if (rsp_tlast != e.last)
                  report($sformatf("last %0d exp %0d", rsp_tlast, e.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: count cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset
          || (pending_samples.size() == 0 && expected_pixels.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         dgu_pkg::CSR_GRID: grid_reg = data;
         dgu_pkg::CSR_GAMMA: gamma_reg = dgu_pkg::gamma_type'(data[1:0]);
         default: filter_reg = data[0];
      endcase
   endtask

   // wait until everything queued is sent and checked, then let the pipe drain
   task automatic drain;
      while (pending_samples.size() > 0 || expected_pixels.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [23:0] random_density();
      case ($urandom_range(0, 5))
         0: return 24'($urandom_range(0, 3));
         1: return 24'd65536;
         2: return 24'($urandom);
         3: return 24'($urandom_range(65530, 65542));
         default: return 24'($urandom_range(0, 65536));
      endcase
   endfunction

   // queue n samples of a w x w raster, frame starts flagged with occasional random flips
   task automatic push_frames(input int n);
      sample_type s;
      int w;
      w = grid_reg + 2;
      for (int i = 0; i < n; i++) begin
         s.density = random_density();
         s.frame_start = (i % (w * w) == 0);
         if ($urandom_range(0, 40) == 0) s.frame_start = 1'b1;
         if ($urandom_range(0, 40) == 0) s.frame_start = 1'b0;
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      sample_type s;
      grid_reg = 9'd101;
      gamma_reg = dgu_pkg::GAMMA_POW34;
      filter_reg = 1'b1;
      row_hist = '{default: '{default: '0}};
      win_hist = '{default: '{default: '0}};
      col_pos = 0;
      row_pos = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest grid, filtered, field extremes
      write_reg(dgu_pkg::CSR_GRID, 9'd1);
      for (int i = 0; i < 20; i++) begin
         s.frame_start = (i == 0 || i == 9);
         case (i % 5)
            0: s.density = 24'd0;
            1: s.density = 24'hFFFFFF;
            2: s.density = 24'd65536;
            3: s.density = 24'd65535;
            default: s.density = 24'h555555 ^ 24'(i);
         endcase
         pending_samples.push_back(s);
      end
      drain();

      // gamma modes, the reserved one included, filter off, grid extremes
      write_reg(dgu_pkg::CSR_GAMMA, dgu_pkg::GAMMA_SQRT);
      write_reg(dgu_pkg::CSR_FILTER, 1'b0);
      push_frames(12);
      drain();
      write_reg(dgu_pkg::CSR_GAMMA, dgu_pkg::GAMMA_RSVD);
      write_reg(dgu_pkg::CSR_GRID, 9'd0);
      push_frames(12);
      drain();
      write_reg(dgu_pkg::CSR_GRID, 9'd511);
      write_reg(dgu_pkg::CSR_GAMMA, dgu_pkg::GAMMA_POW34);
      push_frames(20);
      drain();

      // random part: small grids, filter mostly on
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(dgu_pkg::CSR_GRID, 9'($urandom_range(1, 3)));
         write_reg(dgu_pkg::CSR_GAMMA, 9'($urandom_range(0, 3)));
         write_reg(dgu_pkg::CSR_FILTER, 9'($urandom_range(0, 3) != 0));
         if (ph == 6) quiet_tail = 1;
         push_frames(22);
         drain();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
